// ===== hdl/savf_pkg.sv =====
// shared constants and types for the safe-area integer viewport fit unit
// no dependencies; used by savf_div, savf_ctrl and the top level
package savf_pkg;

    localparam int COORD_W   = 13;
    localparam int SAFE_W    = COORD_W + 2;
    localparam int SCALE_W   = COORD_W + 16;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int DIV_NUM_W = SCALE_W;
    localparam int DIV_PAD_W = DIV_NUM_W - COORD_W;
    localparam int DIV_CNT_W = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOGICAL_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOGICAL_HEIGHT = 2'd1;

    localparam logic [COORD_W-1:0] RESET_LOGICAL_WIDTH  = 13'd640;
    localparam logic [COORD_W-1:0] RESET_LOGICAL_HEIGHT = 13'd480;

    // request to the shared divider; rem must be below den
    typedef struct packed {
        logic                 start;
        logic [COORD_W-1:0]   rem;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_CNT_W-1:0] cnt;
        logic [COORD_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
        logic [COORD_W-1:0]   rem;
    } t_div_rsp;

    typedef struct packed {
        logic               ok;
        logic [COORD_W-1:0] inset_left;
        logic [COORD_W-1:0] inset_top;
        logic [COORD_W-1:0] inset_right;
        logic [COORD_W-1:0] inset_bottom;
        logic [COORD_W-1:0] view_x;
        logic [COORD_W-1:0] view_y;
        logic [COORD_W-1:0] view_width;
        logic [COORD_W-1:0] view_height;
        logic [COORD_W-1:0] aspect_multiple;
        logic [SCALE_W-1:0] scale_q16;
    } t_result;

endpackage

// ===== hdl/savf_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on savf_pkg for widths and the request/response structs
module savf_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  savf_pkg::t_div_req i_req,
    output savf_pkg::t_div_rsp o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [savf_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [savf_pkg::COORD_W-1:0]   r_rem;
    logic [savf_pkg::DIV_NUM_W-1:0] r_num;
    logic [savf_pkg::DIV_NUM_W-1:0] r_quo;
    logic [savf_pkg::COORD_W-1:0]   r_den;

    logic [savf_pkg::COORD_W:0]     w_trial;
    logic [savf_pkg::COORD_W:0]     w_diff;
    logic                           w_ge;

    // partial remainder stays below the divisor, so the difference fits
    assign w_trial = {r_rem, r_num[savf_pkg::DIV_NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == savf_pkg::DIV_CNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.cnt;
            end else if (r_busy) begin
                r_cnt <= r_cnt - savf_pkg::DIV_CNT_W'(1);
                if (r_cnt == savf_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[savf_pkg::COORD_W-1:0] : w_trial[savf_pkg::COORD_W-1:0];
            r_num <= {r_num[savf_pkg::DIV_NUM_W-2:0], 1'b0};
            r_quo <= {r_quo[savf_pkg::DIV_NUM_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== hdl/savf_ctrl.sv =====
// sequencer and datapath registers of the viewport fit: clamp, insets, gcd, fit, scale
// depends on savf_pkg; drives the shared divider savf_div through a request struct
module savf_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic        [savf_pkg::COORD_W-1:0] i_point_width,
    input  logic        [savf_pkg::COORD_W-1:0] i_point_height,
    input  logic        [savf_pkg::COORD_W-1:0] i_pixel_width,
    input  logic        [savf_pkg::COORD_W-1:0] i_pixel_height,
    input  logic signed [savf_pkg::SAFE_W-1:0]  i_safe_x,
    input  logic signed [savf_pkg::SAFE_W-1:0]  i_safe_y,
    input  logic signed [savf_pkg::SAFE_W-1:0]  i_safe_w,
    input  logic signed [savf_pkg::SAFE_W-1:0]  i_safe_h,
    input  logic        [savf_pkg::COORD_W-1:0] i_logical_width,
    input  logic        [savf_pkg::COORD_W-1:0] i_logical_height,
    output savf_pkg::t_div_req                  o_div_req,
    input  savf_pkg::t_div_rsp                  i_div_rsp,
    output logic                                o_done,
    output savf_pkg::t_result                   o_result
);

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_CLAMP    = 5'd1;
    localparam logic [4:0] ST_MUL      = 5'd2;
    localparam logic [4:0] ST_INS_GO   = 5'd3;
    localparam logic [4:0] ST_INS_WAIT = 5'd4;
    localparam logic [4:0] ST_INS_CHK  = 5'd5;
    localparam logic [4:0] ST_GCD      = 5'd6;
    localparam logic [4:0] ST_GCD_WAIT = 5'd7;
    localparam logic [4:0] ST_AW_GO    = 5'd8;
    localparam logic [4:0] ST_AW_WAIT  = 5'd9;
    localparam logic [4:0] ST_AH_GO    = 5'd10;
    localparam logic [4:0] ST_AH_WAIT  = 5'd11;
    localparam logic [4:0] ST_QW_GO    = 5'd12;
    localparam logic [4:0] ST_QW_WAIT  = 5'd13;
    localparam logic [4:0] ST_QH_GO    = 5'd14;
    localparam logic [4:0] ST_QH_WAIT  = 5'd15;
    localparam logic [4:0] ST_FIT      = 5'd16;
    localparam logic [4:0] ST_MULW     = 5'd17;
    localparam logic [4:0] ST_MULH     = 5'd18;
    localparam logic [4:0] ST_SC_GO    = 5'd19;
    localparam logic [4:0] ST_SC_WAIT  = 5'd20;

    localparam int CW = savf_pkg::COORD_W;
    localparam int SW = savf_pkg::SAFE_W;
    localparam int PW = savf_pkg::PROD_W;

    localparam logic [1:0] EDGE_LAST = 2'd3;

    function automatic logic [CW-1:0] clamp_pt(input logic signed [SW:0] v,
                                               input logic [CW-1:0] ext);
        logic signed [SW:0] e;
        logic [CW-1:0]      res;
        e = $signed({{(SW+1-CW){1'b0}}, ext});
        if (v < 0) begin
            res = '0;
        end else if (v > e) begin
            res = ext;
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    logic [4:0]           r_state;
    logic [4:0]           n_state;
    logic                 r_done;
    savf_pkg::t_result    r_result;

    logic [CW-1:0]        r_ptw, r_pth, r_pxw, r_pxh;
    logic signed [SW-1:0] r_sx, r_sy, r_sw, r_sh;
    logic [CW-1:0]        r_ip [4];
    logic [CW-1:0]        r_ins [4];
    logic [1:0]           r_k;
    logic [PW-1:0]        r_prod;
    logic [CW-1:0]        r_areaw, r_areah;
    logic [CW-1:0]        r_ga, r_gb;
    logic [CW-1:0]        r_aw, r_ah, r_qw, r_qh, r_m, r_mw, r_mh;
    logic [CW-1:0]        r_vx, r_vy;

    logic                 w_accept;
    logic signed [SW:0]   w_sx, w_sy, w_ex, w_ey;
    logic [CW-1:0]        w_sl, w_st, w_sr, w_sb;
    logic                 w_bad_in;
    logic [CW-1:0]        w_pts, w_pix;
    logic [CW-1:0]        w_mul_a, w_mul_b;
    logic [PW-1:0]        w_prod;
    logic [CW:0]          w_sum_lr, w_sum_tb;
    logic                 w_bad_ins;
    logic [CW-1:0]        w_m;
    logic                 w_fail;
    logic                 w_finish;

    assign w_accept = i_start && (r_state == ST_IDLE);
    assign o_busy   = r_state != ST_IDLE;

    // safe rectangle edges in points, clamped to the display
    assign w_sx = {r_sx[SW-1], r_sx};
    assign w_sy = {r_sy[SW-1], r_sy};
    assign w_ex = w_sx + {r_sw[SW-1], r_sw};
    assign w_ey = w_sy + {r_sh[SW-1], r_sh};
    assign w_sl = clamp_pt(w_sx, r_ptw);
    assign w_st = clamp_pt(w_sy, r_pth);
    assign w_sr = clamp_pt(w_ex, r_ptw);
    assign w_sb = clamp_pt(w_ey, r_pth);

    assign w_bad_in = (r_ptw == '0) || (r_pth == '0) || (r_pxw == '0) || (r_pxh == '0)
                   || r_sw[SW-1] || (r_sw == '0) || r_sh[SW-1] || (r_sh == '0)
                   || (w_sr <= w_sl) || (w_sb <= w_st);

    // edges 0 and 2 are horizontal, 1 and 3 vertical
    assign w_pts = r_k[0] ? r_pth : r_ptw;
    assign w_pix = r_k[0] ? r_pxh : r_pxw;

    always_comb begin
        unique case (r_state)
            ST_MULW: begin
                w_mul_a = r_aw;
                w_mul_b = r_m;
            end
            ST_MULH: begin
                w_mul_a = r_ah;
                w_mul_b = r_m;
            end
            default: begin
                w_mul_a = r_ip[r_k];
                w_mul_b = w_pix;
            end
        endcase
    end

    assign w_prod = PW'(w_mul_a) * PW'(w_mul_b);

    assign w_sum_lr  = {1'b0, r_ins[0]} + {1'b0, r_ins[2]};
    assign w_sum_tb  = {1'b0, r_ins[1]} + {1'b0, r_ins[3]};
    assign w_bad_ins = (w_sum_lr >= {1'b0, r_pxw}) || (w_sum_tb >= {1'b0, r_pxh})
                    || (i_logical_width == '0) || (i_logical_height == '0);

    assign w_m = (r_qw < r_qh) ? r_qw : r_qh;

    assign w_fail = ((r_state == ST_CLAMP) && w_bad_in)
                 || ((r_state == ST_INS_CHK) && w_bad_ins)
                 || ((r_state == ST_FIT) && (w_m == '0));
    assign w_finish = (r_state == ST_SC_WAIT) && i_div_rsp.done;

    // divider requests; narrow divisions put the dividend at the top of num
    always_comb begin
        o_div_req       = '0;
        o_div_req.cnt   = savf_pkg::DIV_CNT_W'(CW);
        unique case (r_state)
            ST_INS_GO: begin
                o_div_req.start = 1'b1;
                o_div_req.rem   = r_prod[PW-1:CW];
                o_div_req.num   = {r_prod[CW-1:0], {savf_pkg::DIV_PAD_W{1'b0}}};
                o_div_req.den   = w_pts;
            end
            ST_GCD: begin
                o_div_req.start = r_gb != '0;
                o_div_req.num   = {r_ga, {savf_pkg::DIV_PAD_W{1'b0}}};
                o_div_req.den   = r_gb;
            end
            ST_AW_GO: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = {i_logical_width, {savf_pkg::DIV_PAD_W{1'b0}}};
                o_div_req.den   = r_ga;
            end
            ST_AH_GO: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = {i_logical_height, {savf_pkg::DIV_PAD_W{1'b0}}};
                o_div_req.den   = r_ga;
            end
            ST_QW_GO: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = {r_areaw, {savf_pkg::DIV_PAD_W{1'b0}}};
                o_div_req.den   = r_aw;
            end
            ST_QH_GO: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = {r_areah, {savf_pkg::DIV_PAD_W{1'b0}}};
                o_div_req.den   = r_ah;
            end
            ST_SC_GO: begin
                // view width times 65536 over the logical width
                o_div_req.start = 1'b1;
                o_div_req.num   = {r_mw, {savf_pkg::DIV_PAD_W{1'b0}}};
                o_div_req.cnt   = savf_pkg::DIV_CNT_W'(savf_pkg::DIV_NUM_W);
                o_div_req.den   = i_logical_width;
            end
            default: begin
                o_div_req.start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_start) n_state = ST_CLAMP;
            ST_CLAMP:    n_state = w_bad_in ? ST_IDLE : ST_MUL;
            ST_MUL:      n_state = ST_INS_GO;
            ST_INS_GO:   n_state = ST_INS_WAIT;
            ST_INS_WAIT: begin
                if (i_div_rsp.done) begin
                    n_state = (r_k == EDGE_LAST) ? ST_INS_CHK : ST_MUL;
                end
            end
            ST_INS_CHK:  n_state = w_bad_ins ? ST_IDLE : ST_GCD;
            ST_GCD:      n_state = (r_gb == '0) ? ST_AW_GO : ST_GCD_WAIT;
            ST_GCD_WAIT: if (i_div_rsp.done) n_state = ST_GCD;
            ST_AW_GO:    n_state = ST_AW_WAIT;
            ST_AW_WAIT:  if (i_div_rsp.done) n_state = ST_AH_GO;
            ST_AH_GO:    n_state = ST_AH_WAIT;
            ST_AH_WAIT:  if (i_div_rsp.done) n_state = ST_QW_GO;
            ST_QW_GO:    n_state = ST_QW_WAIT;
            ST_QW_WAIT:  if (i_div_rsp.done) n_state = ST_QH_GO;
            ST_QH_GO:    n_state = ST_QH_WAIT;
            ST_QH_WAIT:  if (i_div_rsp.done) n_state = ST_FIT;
            ST_FIT:      n_state = (w_m == '0) ? ST_IDLE : ST_MULW;
            ST_MULW:     n_state = ST_MULH;
            ST_MULH:     n_state = ST_SC_GO;
            ST_SC_GO:    n_state = ST_SC_WAIT;
            ST_SC_WAIT:  if (i_div_rsp.done) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_fail || w_finish;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_ptw <= i_point_width;
                    r_pth <= i_point_height;
                    r_pxw <= i_pixel_width;
                    r_pxh <= i_pixel_height;
                    r_sx  <= i_safe_x;
                    r_sy  <= i_safe_y;
                    r_sw  <= i_safe_w;
                    r_sh  <= i_safe_h;
                end
            end
            ST_CLAMP: begin
                r_ip[0] <= w_sl;
                r_ip[1] <= w_st;
                r_ip[2] <= r_ptw - w_sr;
                r_ip[3] <= r_pth - w_sb;
                r_k     <= '0;
            end
            ST_MUL: begin
                // ceiling division: add points minus one before dividing
                r_prod <= w_prod + PW'(w_pts) - PW'(1);
            end
            ST_INS_WAIT: begin
                if (i_div_rsp.done) begin
                    r_ins[r_k] <= i_div_rsp.quo[CW-1:0];
                    r_k        <= r_k + 2'd1;
                end
            end
            ST_INS_CHK: begin
                r_areaw <= r_pxw - r_ins[0] - r_ins[2];
                r_areah <= r_pxh - r_ins[1] - r_ins[3];
                r_ga    <= i_logical_width;
                r_gb    <= i_logical_height;
            end
            ST_GCD_WAIT: begin
                if (i_div_rsp.done) begin
                    r_ga <= r_gb;
                    r_gb <= i_div_rsp.rem;
                end
            end
            ST_AW_WAIT: if (i_div_rsp.done) r_aw <= i_div_rsp.quo[CW-1:0];
            ST_AH_WAIT: if (i_div_rsp.done) r_ah <= i_div_rsp.quo[CW-1:0];
            ST_QW_WAIT: if (i_div_rsp.done) r_qw <= i_div_rsp.quo[CW-1:0];
            ST_QH_WAIT: if (i_div_rsp.done) r_qh <= i_div_rsp.quo[CW-1:0];
            ST_FIT:     r_m  <= w_m;
            ST_MULW:    r_mw <= w_prod[CW-1:0];
            ST_MULH:    r_mh <= w_prod[CW-1:0];
            ST_SC_GO: begin
                // leftover split evenly, odd pixel goes to the far side
                r_vx <= r_ins[0] + ((r_areaw - r_mw) >> 1);
                r_vy <= r_ins[1] + ((r_areah - r_mh) >> 1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_fail) begin
            r_result <= '0;
        end else if (w_finish) begin
            r_result.ok              <= 1'b1;
            r_result.inset_left      <= r_ins[0];
            r_result.inset_top       <= r_ins[1];
            r_result.inset_right     <= r_ins[2];
            r_result.inset_bottom    <= r_ins[3];
            r_result.view_x          <= r_vx;
            r_result.view_y          <= r_vy;
            r_result.view_width      <= r_mw;
            r_result.view_height     <= r_mh;
            r_result.aspect_multiple <= r_m;
            r_result.scale_q16       <= i_div_rsp.quo[savf_pkg::SCALE_W-1:0];
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== hdl/safe_area_integer_viewport_fit_unit.sv =====
// top level of the safe-area integer viewport fit unit: config registers and ports
// depends on savf_pkg, savf_div and savf_ctrl
//
// A transaction starts when i_start is high while o_busy is low; the block then
// works on that one item and raises o_busy until the result is out. The result
// appears on the o_ fields with o_done high for exactly one cycle and cannot be
// held off, so capture it on that cycle. o_busy drops in the same cycle that
// o_done rises. Most of the work runs through the single shared restoring
// divider, which makes one quotient bit per cycle: four 13-bit divisions for
// the rounded-up insets, one per Euclid step of the gcd of the logical size
// (1 to 19 steps, set by the configured values), four more for the aspect
// ratio and the fit, and a 29-bit division for the Q13.16 scale. Invalid items
// finish early with o_ok low and every field zero. Configuration writes are
// always taken (o_cfg_ready stays high), indexes other than 0 and 1 are
// ignored, and writes belong in idle time.
module safe_area_integer_viewport_fit_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic        [savf_pkg::COORD_W-1:0]   i_point_width,
    input  logic        [savf_pkg::COORD_W-1:0]   i_point_height,
    input  logic        [savf_pkg::COORD_W-1:0]   i_pixel_width,
    input  logic        [savf_pkg::COORD_W-1:0]   i_pixel_height,
    input  logic signed [savf_pkg::SAFE_W-1:0]    i_safe_x,
    input  logic signed [savf_pkg::SAFE_W-1:0]    i_safe_y,
    input  logic signed [savf_pkg::SAFE_W-1:0]    i_safe_w,
    input  logic signed [savf_pkg::SAFE_W-1:0]    i_safe_h,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic        [savf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [savf_pkg::COORD_W-1:0]   i_cfg_data,
    output logic                                  o_done,
    output logic                                  o_ok,
    output logic        [savf_pkg::COORD_W-1:0]   o_inset_left,
    output logic        [savf_pkg::COORD_W-1:0]   o_inset_top,
    output logic        [savf_pkg::COORD_W-1:0]   o_inset_right,
    output logic        [savf_pkg::COORD_W-1:0]   o_inset_bottom,
    output logic        [savf_pkg::COORD_W-1:0]   o_view_x,
    output logic        [savf_pkg::COORD_W-1:0]   o_view_y,
    output logic        [savf_pkg::COORD_W-1:0]   o_view_width,
    output logic        [savf_pkg::COORD_W-1:0]   o_view_height,
    output logic        [savf_pkg::COORD_W-1:0]   o_aspect_multiple,
    output logic        [savf_pkg::SCALE_W-1:0]   o_scale_q16
);

    logic [savf_pkg::COORD_W-1:0] r_logical_width;
    logic [savf_pkg::COORD_W-1:0] r_logical_height;

    savf_pkg::t_div_req w_div_req;
    savf_pkg::t_div_rsp w_div_rsp;
    savf_pkg::t_result  w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_logical_width  <= savf_pkg::RESET_LOGICAL_WIDTH;
            r_logical_height <= savf_pkg::RESET_LOGICAL_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                savf_pkg::CFG_LOGICAL_WIDTH:  r_logical_width  <= i_cfg_data;
                savf_pkg::CFG_LOGICAL_HEIGHT: r_logical_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    savf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    savf_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_point_width    (i_point_width),
        .i_point_height   (i_point_height),
        .i_pixel_width    (i_pixel_width),
        .i_pixel_height   (i_pixel_height),
        .i_safe_x         (i_safe_x),
        .i_safe_y         (i_safe_y),
        .i_safe_w         (i_safe_w),
        .i_safe_h         (i_safe_h),
        .i_logical_width  (r_logical_width),
        .i_logical_height (r_logical_height),
        .o_div_req        (w_div_req),
        .i_div_rsp        (w_div_rsp),
        .o_done           (o_done),
        .o_result         (w_result)
    );

    assign o_ok              = w_result.ok;
    assign o_inset_left      = w_result.inset_left;
    assign o_inset_top       = w_result.inset_top;
    assign o_inset_right     = w_result.inset_right;
    assign o_inset_bottom    = w_result.inset_bottom;
    assign o_view_x          = w_result.view_x;
    assign o_view_y          = w_result.view_y;
    assign o_view_width      = w_result.view_width;
    assign o_view_height     = w_result.view_height;
    assign o_aspect_multiple = w_result.aspect_multiple;
    assign o_scale_q16       = w_result.scale_q16;

endmodule
